/* sv/ssc_pkg.sv */
// ----------------------------------------------------------------------------
// ssc_pkg: shared types and constants of the save marker signature scanner
// Holds the channel payload structs, the cell interface structs, the pattern
// codes and the pattern text lookup used by every window cell.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

  // Window geometry. Position WIN_LEN-1 holds the newest byte.
  localparam int WIN_LEN     = 14;
  localparam int DIGIT_FIRST = 10;
  localparam int NUL_POS     = 13;
  localparam int PREFIX_END  = 9;

  // Pattern codes. The first six are versioned prefixes, the last is the
  // bare flash 512K text.
  localparam int NUM_PAT       = 7;
  localparam int PAT_FLASH1M   = 0;
  localparam int PAT_FLASH512V = 1;
  localparam int PAT_FLASHV    = 2;
  localparam int PAT_EEPROMV   = 3;
  localparam int PAT_SRAMV     = 4;
  localparam int PAT_SRAMFV    = 5;
  localparam int PAT_BARE512   = 6;

  // Family bits of the mask.
  localparam int FAM_FLASH1M  = 0;
  localparam int FAM_FLASH512 = 1;
  localparam int FAM_EEPROM   = 2;
  localparam int FAM_SRAM     = 3;
  localparam int NUM_FAM      = 4;

  // Verdict status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NONE  = 2'd1;
  localparam logic [1:0] STAT_MULTI = 2'd2;

  // Bare text count saturates here.
  localparam logic [1:0] BARE_SAT = 2'd2;

  typedef struct packed {
    logic [7:0] rom_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] save_type;
    logic [1:0] detect_status;
    logic [3:0] family_mask;
  } out_item_t;

  // Control that every cell of the window receives.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // Compare results of one cell for the byte it is about to hold.
  typedef struct packed {
    logic [NUM_PAT-1:0] match;
    logic               is_digit;
    logic               is_nul;
  } cell_flags_t;

  // Versioned prefixes are built as a family stem followed by the version tag.
  function automatic logic [79:0] pat_text(input int p);
    logic [79:0] t;
    t = '0;
    case (p)
      PAT_FLASH1M:   t = 80'({"FLASH1M", "_V"});
      PAT_FLASH512V: t = 80'({"FLASH512", "_V"});
      PAT_FLASHV:    t = 80'({"FLASH", "_V"});
      PAT_EEPROMV:   t = 80'({"EEPROM", "_V"});
      PAT_SRAMV:     t = 80'({"SRAM", "_V"});
      PAT_SRAMFV:    t = 80'({"SRAM_F", "_V"});
      PAT_BARE512:   t = 80'("FLASH512");
      default:       t = '0;
    endcase
    return t;
  endfunction

  function automatic int pat_len(input int p);
    int n;
    n = 0;
    case (p)
      PAT_FLASH1M:   n = 9;
      PAT_FLASH512V: n = 10;
      PAT_FLASHV:    n = 7;
      PAT_EEPROMV:   n = 8;
      PAT_SRAMV:     n = 6;
      PAT_SRAMFV:    n = 8;
      PAT_BARE512:   n = 8;
      default:       n = 0;
    endcase
    return n;
  endfunction

  // Returns {care, expected byte} of pattern p at window position pos.
  function automatic logic [8:0] pat_entry(input int p, input int pos);
    int          len;
    int          last_pos;
    int          first_pos;
    int          off;
    logic [79:0] txt;
    logic [8:0]  e;
    len       = pat_len(p);
    last_pos  = (p == PAT_BARE512) ? (WIN_LEN - 1) : PREFIX_END;
    first_pos = last_pos - len + 1;
    txt       = pat_text(p);
    e         = '0;
    if (pos >= first_pos && pos <= last_pos) begin
      off = pos - first_pos;
      e   = {1'b1, txt[(len - 1 - off) * 8 +: 8]};
    end
    return e;
  endfunction

endpackage

`default_nettype wire

/* sv/save_marker_signature_scanner.sv */
// ----------------------------------------------------------------------------
// save_marker_signature_scanner: save library marker scanner
// Streams a ROM image through a 14-byte window of cells, records which save
// families carry a versioned marker and gives one verdict per image.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload      transfer gives
//   in_*      input      in_item_t    one ROM byte, last_byte ends the image
//   out_*     output     out_item_t   one verdict per image
//
// One byte is taken per cycle; the window cells, the marker AND trees and the
// family flags all update in the same cycle as the transfer. A verdict appears
// in the output register in the cycle after the transfer of the last byte.
// Reset is synchronous and active low; it zeroes the window, the flags, the
// bare text count and the output valid. The input stalls only while a verdict
// waits in the output register and the output side is not ready.
//
`default_nettype none

module save_marker_signature_scanner (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  ssc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output ssc_pkg::out_item_t  out_data
);
  import ssc_pkg::*;

  // Handshake. The output register frees itself in the same cycle that its
  // verdict is taken, so a new byte is taken back to back.
  logic      in_xfer;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_data_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // The window. Cell WIN_LEN-1 loads the new byte, every other cell loads
  // its newer neighbor. The last byte of an image clears the whole row.
  cell_ctl_t   ctl;
  logic [7:0]  cell_q [WIN_LEN];
  cell_flags_t flags  [WIN_LEN];

  assign ctl.shift = in_xfer;
  assign ctl.clear = in_data.last_byte;

  genvar k;
  generate
    for (k = 0; k < WIN_LEN; k++) begin : g_cell
      logic [7:0] d_in;
      if (k == WIN_LEN - 1) begin : g_head
        assign d_in = in_data.rom_byte;
      end else begin : g_body
        assign d_in = cell_q[k + 1];
      end
      ssc_cell #(
        .POS (k)
      ) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .d_in  (d_in),
        .q     (cell_q[k]),
        .flags (flags[k])
      );
    end
  endgenerate

  // A pattern matches when every cell agrees with it. Each cell already
  // reports a match for positions that the pattern does not cover.
  logic [NUM_PAT-1:0] all_match;
  logic               tail_ok;
  logic [3:0]         fam_hit;
  logic               bare_hit;

  always_comb begin
    all_match = '1;
    for (int i = 0; i < WIN_LEN; i++) begin
      all_match = all_match & flags[i].match;
    end
  end

  // A versioned marker needs three digits after the prefix and a NUL in the
  // newest position.
  assign tail_ok = flags[DIGIT_FIRST].is_digit && flags[DIGIT_FIRST + 1].is_digit &&
                   flags[DIGIT_FIRST + 2].is_digit && flags[NUL_POS].is_nul;

  always_comb begin
    fam_hit = '0;
    if (tail_ok) begin
      fam_hit[FAM_FLASH1M]  = all_match[PAT_FLASH1M];
      fam_hit[FAM_FLASH512] = all_match[PAT_FLASH512V] || all_match[PAT_FLASHV];
      fam_hit[FAM_EEPROM]   = all_match[PAT_EEPROMV];
      fam_hit[FAM_SRAM]     = all_match[PAT_SRAMV] || all_match[PAT_SRAMFV];
    end
  end

  assign bare_hit = all_match[PAT_BARE512];

  // Family flags and the saturating bare text count. The verdict is formed
  // from their next values, so the last byte's own hits are included.
  logic [3:0] found_r;
  logic [3:0] found_nxt;
  logic [1:0] bare_cnt_r;
  logic [1:0] bare_cnt_nxt;
  out_item_t  verdict;

  assign found_nxt    = found_r | fam_hit;
  assign bare_cnt_nxt = (bare_hit && (bare_cnt_r < BARE_SAT)) ? (bare_cnt_r + 2'd1)
                                                              : bare_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r    <= '0;
      bare_cnt_r <= '0;
    end else if (in_xfer) begin
      if (in_data.last_byte) begin
        found_r    <= '0;
        bare_cnt_r <= '0;
      end else begin
        found_r    <= found_nxt;
        bare_cnt_r <= bare_cnt_nxt;
      end
    end
  end

  ssc_verdict u_verdict (
    .found      (found_nxt),
    .bare_count (bare_cnt_nxt),
    .verdict    (verdict)
  );

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_xfer && in_data.last_byte) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_data.last_byte) begin
      out_data_r <= verdict;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* sv/ssc_cell.sv */
// ----------------------------------------------------------------------------
// ssc_cell: one byte position of the scan window
// Holds one window byte, passes it to the older neighbor on each shift and
// compares the byte it is about to load against every pattern's character
// at its own position.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_cell #(
  parameter int POS = 0
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  ssc_pkg::cell_ctl_t  ctl,
  input  wire [7:0]           d_in,
  output logic [7:0]          q,
  output ssc_pkg::cell_flags_t flags
);
  import ssc_pkg::*;

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  assign byte_nxt = ctl.clear ? 8'd0 : d_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'd0;
    end else if (ctl.shift) begin
      byte_r <= byte_nxt;
    end
  end

  assign q = byte_r;

  genvar p;
  generate
    for (p = 0; p < NUM_PAT; p++) begin : g_pat
      localparam logic [8:0] ENTRY = pat_entry(p, POS);
      assign flags.match[p] = !ENTRY[8] || (d_in == ENTRY[7:0]);
    end
  endgenerate

  assign flags.is_digit = (d_in >= 8'h30) && (d_in <= 8'h39);
  assign flags.is_nul   = (d_in == 8'h00);

endmodule

`default_nettype wire

/* sv/ssc_verdict.sv */
// ----------------------------------------------------------------------------
// ssc_verdict: end-of-image verdict
// Folds the bare flash 512K count into the family mask and encodes the save
// type and the detection status.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_verdict (
  input  wire [3:0]          found,
  input  wire [1:0]          bare_count,
  output ssc_pkg::out_item_t verdict
);
  import ssc_pkg::*;

  logic [3:0] mask;
  logic [2:0] n_set;
  logic [1:0] type_idx;

  always_comb begin
    mask = found;
    if (!found[FAM_FLASH512] && (bare_count == 2'd1)) begin
      mask[FAM_FLASH512] = 1'b1;
    end
    n_set    = 3'd0;
    type_idx = 2'd0;
    for (int i = 0; i < NUM_FAM; i++) begin
      if (mask[i]) begin
        n_set    = n_set + 3'd1;
        type_idx = 2'(i);
      end
    end
    verdict.family_mask = mask;
    if (n_set == 3'd0) begin
      verdict.detect_status = STAT_NONE;
      verdict.save_type     = 2'd0;
    end else if (n_set == 3'd1) begin
      verdict.detect_status = STAT_OK;
      verdict.save_type     = type_idx;
    end else begin
      verdict.detect_status = STAT_MULTI;
      verdict.save_type     = 2'd0;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the save marker signature scanner
// Streams short ROM images through the scanner, predicts one verdict per image
// from its own copy of the byte window, and checks every verdict field.
// ----------------------------------------------------------------------------

// Expected verdicts, computed from a private copy of the scanner state.
class verdict_board;
  localparam int WINDOW_BYTES = 14;
  localparam int PREFIX_LAST  = 9;
  localparam int NEWEST       = 13;

  logic [7:0] window [WINDOW_BYTES];
  logic [3:0] families_seen;
  logic [1:0] bare_hits;
  ssc_pkg::out_item_t verdicts_due[$];
  int mismatches;

  function new();
    mismatches = 0;
    clear_image();
  endfunction

  function void clear_image();
    foreach (window[i]) window[i] = 8'h00;
    families_seen = 4'b0000;
    bare_hits     = 2'd0;
  endfunction

  function int pending();
    return verdicts_due.size();
  endfunction

  // A versioned prefix is a family stem followed by the version tag.
  function string vtag(string stem);
    return {stem, "_V"};
  endfunction

  // True when the text s sits in the window with its last character at end_pos.
  function bit text_ends_at(string s, int end_pos);
    int n;
    int k;
    n = s.len();
    for (k = 0; k < n; k++) begin
      if (window[end_pos - n + 1 + k] != s[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function bit is_dec(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  task report_mismatch(string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  // Called for every accepted input transfer.
  function void note_byte(ssc_pkg::in_item_t it);
    ssc_pkg::out_item_t v;
    logic [3:0] mask;
    int n;
    int kind;
    int i;
    for (i = 0; i < WINDOW_BYTES - 1; i++) window[i] = window[i + 1];
    window[NEWEST] = it.rom_byte;

    // A versioned marker completes on its NUL, with three digits before it.
    if (it.rom_byte == 8'h00 && is_dec(window[10]) && is_dec(window[11]) &&
        is_dec(window[12])) begin
      if (text_ends_at(vtag("FLASH1M"), PREFIX_LAST))
        families_seen[ssc_pkg::FAM_FLASH1M] = 1'b1;
      if (text_ends_at(vtag("FLASH512"), PREFIX_LAST))
        families_seen[ssc_pkg::FAM_FLASH512] = 1'b1;
      if (text_ends_at(vtag("FLASH"), PREFIX_LAST))
        families_seen[ssc_pkg::FAM_FLASH512] = 1'b1;
      if (text_ends_at(vtag("EEPROM"), PREFIX_LAST))
        families_seen[ssc_pkg::FAM_EEPROM] = 1'b1;
      if (text_ends_at(vtag("SRAM"), PREFIX_LAST))
        families_seen[ssc_pkg::FAM_SRAM] = 1'b1;
      if (text_ends_at(vtag("SRAM_F"), PREFIX_LAST))
        families_seen[ssc_pkg::FAM_SRAM] = 1'b1;
    end

    if (text_ends_at("FLASH512", NEWEST) && bare_hits < ssc_pkg::BARE_SAT)
      bare_hits = bare_hits + 2'd1;

    if (!it.last_byte) return;

    mask = families_seen;
    if (!mask[ssc_pkg::FAM_FLASH512] && bare_hits == 2'd1)
      mask[ssc_pkg::FAM_FLASH512] = 1'b1;
    n    = 0;
    kind = 0;
    for (i = 0; i < ssc_pkg::NUM_FAM; i++) begin
      if (mask[i]) begin
        n++;
        kind = i;
      end
    end
    v.family_mask = mask;
    if (n == 0) begin
      v.detect_status = ssc_pkg::STAT_NONE;
      v.save_type     = 2'd0;
    end else if (n == 1) begin
      v.detect_status = ssc_pkg::STAT_OK;
      v.save_type     = 2'(kind);
    end else begin
      v.detect_status = ssc_pkg::STAT_MULTI;
      v.save_type     = 2'd0;
    end
    verdicts_due = {verdicts_due, v};
    clear_image();
  endfunction

  // Called for every accepted output transfer.
  task check_verdict(ssc_pkg::out_item_t got);
    ssc_pkg::out_item_t want;
    if (verdicts_due.size() == 0) begin
      report_mismatch($sformatf("verdict %h with none pending", got));
      return;
    end
    want = verdicts_due.pop_front();
    if (got.save_type != want.save_type)
      report_mismatch($sformatf("save_type %0d, want %0d", got.save_type, want.save_type));
    if (got.detect_status != want.detect_status)
      report_mismatch($sformatf("detect_status %0d, want %0d",
                                got.detect_status, want.detect_status));
    if (got.family_mask != want.family_mask)
      report_mismatch($sformatf("family_mask %b, want %b", got.family_mask, want.family_mask));
  endtask
endclass

module tb;
  import ssc_pkg::*;

  typedef logic [7:0] rom_q_t[$];

  // Idle chance per cycle in percent, input bytes to send, and images to see.
  localparam int IDLE_PCT     = 28;
  localparam int BYTE_TARGET  = 700;
  localparam int IMAGE_TARGET = 40;
  // Receiver hold-off length; long enough to fill the block and stall input.
  localparam int HOLD_CYCLES  = 200;
  // Watchdog: cycles without any transfer. The longest legal quiet spell is
  // the hold-off plus a short random gap, so this is several times that.
  localparam int QUIET_LIMIT  = 2000;
  // Cycles to wait after the last verdict.
  localparam int DRAIN_CYCLES = 8;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  verdict_board board;
  bit           no_gaps   = 1'b0;  // both sides run without idling while set
  bit           hold_req  = 1'b0;  // asks the receiver for one long hold-off
  int           bytes_sent = 0;
  int           quiet_cycles = 0;

  save_marker_signature_scanner DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog. Any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side. Values read right after the edge are the ones the edge saw,
  // since every signal on both sides changes through nonblocking updates.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) board.check_verdict(out_data);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offers one byte and returns once its transfer has happened. Valid stays
  // high from one byte to the next unless a random gap is taken.
  task automatic send_byte(input in_item_t it);
    if (!no_gaps) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_byte(it);
    bytes_sent++;
  endtask

  // The final byte of the image carries last_byte, which asks for a verdict.
  task automatic send_image(input rom_q_t img);
    in_item_t it;
    foreach (img[i]) begin
      it.rom_byte  = img[i];
      it.last_byte = (i == img.size() - 1);
      send_byte(it);
    end
  endtask

  function automatic void push_text(ref rom_q_t img, input string s);
    for (int k = 0; k < s.len(); k++) img = {img, 8'(s[k])};
  endfunction

  function automatic string random_prefix();
    string stem;
    case ($urandom_range(5))
      0:       stem = "FLASH1M";
      1:       stem = "FLASH512";
      2:       stem = "FLASH";
      3:       stem = "EEPROM";
      4:       stem = "SRAM";
      default: stem = "SRAM_F";
    endcase
    return {stem, "_V"};
  endfunction

  // Prefix, three decimal digits and the closing NUL.
  function automatic void push_marker(ref rom_q_t img);
    push_text(img, random_prefix());
    repeat (3) img = {img, 8'h30 + 8'($urandom_range(9))};
    img = {img, 8'h00};
  endfunction

  // An image is a few segments: clean markers, bare flash 512K text, markers
  // with one byte spoiled or the NUL missing, and noise that leans toward
  // marker letters and digits so near misses are common.
  function automatic rom_q_t random_image();
    rom_q_t img;
    string  letters;
    int     segs;
    int     start;
    int     n;
    letters = "FLASH512_VEPROM";
    segs    = $urandom_range(3);
    repeat (segs) begin
      start = img.size();
      case ($urandom_range(9))
        0, 1, 2, 3: push_marker(img);
        4:          push_text(img, "FLASH512");
        5, 6: begin
          push_marker(img);
          if ($urandom_range(1)) void'(img.pop_back());
          else img[start + $urandom_range(img.size() - start - 1)] = 8'($urandom_range(255));
        end
        default: begin
          n = $urandom_range(1, 6);
          repeat (n) begin
            case ($urandom_range(3))
              0, 1:    img = {img, 8'($urandom_range(255))};
              2:       img = {img, 8'h30 + 8'($urandom_range(9))};
              default: img = {img, 8'(letters[$urandom_range(letters.len() - 1)])};
            endcase
          end
        end
      endcase
    end
    if (img.size() == 0) img = {img, 8'($urandom_range(255))};
    return img;
  endfunction

  initial begin
    rom_q_t img;
    int     images;
    board = new();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed images. The first is a versioned flash 512K marker cut short
    // by the end of the image; the bare text inside it still counts once, so
    // the family is present through the bare text alone.
    img = {};
    push_text(img, "FLASH512");
    push_text(img, "_V123");
    send_image(img);
    // A marker right at the start of an image, closed by the last byte.
    img = {};
    push_text(img, "EEPROM");
    push_text(img, "_V000");
    img = {img, 8'h00};
    send_image(img);
    // One-byte images at both byte extremes; the NUL must not match against
    // the zero-filled window.
    send_image({8'hFF});
    send_image({8'h00});

    images = 0;
    while (bytes_sent < BYTE_TARGET || images < IMAGE_TARGET) begin
      // The receiver holds off while bytes keep coming, so a verdict waits
      // in the output register and the input side has to stall.
      if (images == 8) hold_req = 1'b1;
      // Let every pending verdict drain before the next image starts.
      if (images == 16) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
      end
      if (images == 22) no_gaps = 1'b1;
      if (images == 32) no_gaps = 1'b0;
      send_image(random_image());
      images++;
    end

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
